// ----- hw/rtl/sliding_window_zscore_severity_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef SLIDING_WINDOW_ZSCORE_SEVERITY_MACROS_SVH
`define SLIDING_WINDOW_ZSCORE_SEVERITY_MACROS_SVH

// Property checked outside reset.
`define SWZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked in and out of reset.
`define SWZ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/swz_pkg.sv -----
// Shared types and constants for the sliding window z-score block.
// No dependencies.
package swz_pkg;

  localparam int WIN_MAX = 64;
  localparam int LEN_W   = $clog2(WIN_MAX + 1);
  localparam int PTR_W   = $clog2(WIN_MAX);
  localparam int SUM_W   = 16 + PTR_W;
  localparam int SQ_W    = 32 + PTR_W;
  localparam int D_W     = 2 * SUM_W;
  localparam int NUM_W   = 2 * SUM_W + 16;

  // squared severity cutoffs, Q8.8 thresholds 4.0, 3.0, 2.0
  localparam logic [31:0] Z4_SQ = 32'd1048576;
  localparam logic [31:0] Z3_SQ = 32'd589824;
  localparam logic [31:0] Z2_SQ = 32'd262144;

  localparam logic [15:0] LOGINS_CRIT = 16'd50;
  localparam logic [15:0] LOGINS_HIGH = 16'd20;
  localparam logic [15:0] LOGINS_MED  = 16'd5;
  localparam logic [15:0] SCANS_HIGH  = 16'd100;
  localparam logic [15:0] SCANS_MED   = 16'd10;

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_Z_THRESHOLD   = 1'b1
  } swz_reg_e;

  typedef enum logic [1:0] {
    SEV_LOW  = 2'd0,
    SEV_MED  = 2'd1,
    SEV_HIGH = 2'd2,
    SEV_CRIT = 2'd3
  } swz_sev_e;

  typedef enum logic [1:0] {
    F_IDLE, F_UPD, F_MUL, F_DIFF
  } swz_fstate_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SQ, B_DIV, B_ROOT, B_DONE
  } swz_bstate_t;

  // one item handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [D_W-1:0]   d;
    logic [15:0]      logins;
    logic [15:0]      scans;
    logic             root;
  } swz_job_t;

  // queue handshake between the two halves
  typedef struct packed {
    logic push;
    logic pop;
  } swz_qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } swz_qsts_t;

endpackage

// ----- hw/rtl/sliding_window_zscore_severity.sv -----
// Sliding window z-score detector. An accepted item passes the front states (window
// update, multiply, difference), the queue hand-off, a setup step, 60 divide steps,
// 16 square root steps and the output register; a zero radicand skips both.
// Back works on one item at a time; front accepts the next after queuing the last.
// Synchronous reset empties the window and sets window_length 60, z_threshold 3.0.
module sliding_window_zscore_severity (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] traffic_sample,
  input  logic [15:0] login_fails,
  input  logic [15:0] scan_count,
  input  logic        root_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] z_score,
  output logic        anomaly,
  output logic [1:0]  severity,
  output logic        report
);
  import swz_pkg::*;

  logic [LEN_W-1:0] window_length;
  logic [15:0]      z_threshold;
  logic             cfg_clear;
  swz_job_t         wr_job;
  swz_job_t         rd_job;
  swz_qctl_t        qctl;
  swz_qsts_t        qsts;
  logic             q_push;
  logic             q_pop;

  assign cfg_clear = cfg_write && (cfg_index == REG_WINDOW_LENGTH);
  assign qctl      = '{push: q_push, pop: q_pop};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_W'(60);
      z_threshold   <= 16'd768;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[LEN_W-1:0];
        REG_Z_THRESHOLD:   z_threshold   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  swz_front u_front (
    .clk            (clk),
    .rst            (rst),
    .window_length  (window_length),
    .cfg_clear      (cfg_clear),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .traffic_sample (traffic_sample),
    .login_fails    (login_fails),
    .scan_count     (scan_count),
    .root_flag      (root_flag),
    .job            (wr_job),
    .job_push       (q_push),
    .job_full       (qsts.full)
  );

  swz_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .ctl    (qctl),
    .sts    (qsts),
    .wr_job (wr_job),
    .rd_job (rd_job)
  );

  swz_back u_back (
    .clk         (clk),
    .rst         (rst),
    .z_threshold (z_threshold),
    .job         (rd_job),
    .job_empty   (qsts.empty),
    .job_pop     (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .z_score     (z_score),
    .anomaly     (anomaly),
    .severity    (severity),
    .report      (report)
  );

endmodule

// ----- hw/rtl/swz_front.sv -----
// Front half: window ring, running sums, deviation numerator and radicand.
// Depends on swz_pkg.
module swz_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [swz_pkg::LEN_W-1:0] window_length,
  input  logic                      cfg_clear,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [15:0]               traffic_sample,
  input  logic [15:0]               login_fails,
  input  logic [15:0]               scan_count,
  input  logic                      root_flag,
  output swz_pkg::swz_job_t         job,
  output logic                      job_push,
  input  logic                      job_full
);
  import swz_pkg::*;

  swz_fstate_t state, state_next;

  logic [15:0]      ring [WIN_MAX];
  logic [15:0]      rd_data;
  logic [LEN_W-1:0] fill;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_cur;
  logic             evict;
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sq;
  logic [15:0]      x;
  logic [31:0]      xsq;
  logic [15:0]      logins;
  logic [15:0]      scans;
  logic             root;
  logic [SUM_W:0]   nx;
  logic [SQ_W+LEN_W-1:0] nq;
  logic [D_W-1:0]   ss;
  logic             n_ge2;

  logic [LEN_W-1:0] len;
  logic [PTR_W-1:0] ptr_use;
  logic [LEN_W-1:0] ptr_inc;
  logic [15:0]      old;
  logic [31:0]      old_sq;
  logic             accept;

  // effective window length, clamped to 1..WIN_MAX
  always_comb begin
    if (window_length == '0) begin
      len = LEN_W'(1);
    end else if (window_length > LEN_W'(WIN_MAX)) begin
      len = LEN_W'(WIN_MAX);
    end else begin
      len = window_length;
    end
  end

  assign ptr_use  = ({1'b0, ptr} >= len) ? '0 : ptr;
  assign ptr_inc  = {1'b0, ptr_cur} + LEN_W'(1);
  assign old      = evict ? rd_data : 16'd0;
  assign old_sq   = 32'(old) * 32'(old);
  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid && !in_stall;

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= ring[ptr_use];
    end
    if (state == F_UPD) begin
      ring[ptr_cur] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_push   = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) state_next = F_UPD;
      end
      F_UPD:  state_next = F_MUL;
      F_MUL:  state_next = F_DIFF;
      F_DIFF: begin
        if (!job_full) begin
          job_push   = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // window control state
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      fill <= '0;
      ptr  <= '0;
      sum  <= '0;
      sq   <= '0;
    end else if (state == F_UPD) begin
      fill <= evict ? len : fill + LEN_W'(1);
      ptr  <= (ptr_inc >= len) ? '0 : ptr_inc[PTR_W-1:0];
      sum  <= sum - SUM_W'(old) + SUM_W'(x);
      sq   <= sq - SQ_W'(old_sq) + SQ_W'(xsq);
    end
  end

  // item capture and products
  always_ff @(posedge clk) begin
    if (accept) begin
      x       <= traffic_sample;
      xsq     <= 32'(traffic_sample) * 32'(traffic_sample);
      logins  <= login_fails;
      scans   <= scan_count;
      root    <= root_flag;
      ptr_cur <= ptr_use;
      evict   <= (fill >= len);
    end
    if (state == F_MUL) begin
      nx    <= (SUM_W+1)'(fill) * (SUM_W+1)'(x);
      nq    <= (SQ_W+LEN_W)'(fill) * (SQ_W+LEN_W)'(sq);
      ss    <= D_W'(sum) * D_W'(sum);
      n_ge2 <= (fill >= LEN_W'(2));
    end
  end

  // |n*x - S| and n*Q - S^2, both zero with fewer than two samples
  always_comb begin
    job.logins = logins;
    job.scans  = scans;
    job.root   = root;
    if (!n_ge2) begin
      job.a = '0;
      job.d = '0;
    end else begin
      if (nx >= {1'b0, sum}) begin
        job.a = SUM_W'(nx - {1'b0, sum});
      end else begin
        job.a = SUM_W'({1'b0, sum} - nx);
      end
      job.d = D_W'(nq - (SQ_W+LEN_W)'(ss));
    end
  end

endmodule

// ----- hw/rtl/swz_fifo.sv -----
// Two-entry queue carrying items from front to back.
// Depends on swz_pkg.
module swz_fifo (
  input  logic               clk,
  input  logic               rst,
  input  swz_pkg::swz_qctl_t ctl,
  output swz_pkg::swz_qsts_t sts,
  input  swz_pkg::swz_job_t  wr_job,
  output swz_pkg::swz_job_t  rd_job
);
  import swz_pkg::*;

  swz_job_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign sts.full  = (count == 2'd2);
  assign sts.empty = (count == 2'd0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (ctl.push) wr_ptr <= ~wr_ptr;
      if (ctl.pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, ctl.push} - {1'b0, ctl.pop};
    end
  end

endmodule

// ----- hw/rtl/swz_back.sv -----
// Back half: z-score by serial divide and integer square root, severity rules.
// Depends on swz_pkg.
module swz_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       z_threshold,
  input  swz_pkg::swz_job_t job,
  input  logic              job_empty,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       z_score,
  output logic              anomaly,
  output logic [1:0]        severity,
  output logic              report
);
  import swz_pkg::*;

  swz_bstate_t state, state_next;

  swz_job_t         cur;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quo;
  logic [D_W:0]     rem;
  logic [5:0]       step;
  logic [31:0]      tsq;
  logic [15:0]      root_k;
  logic [3:0]       bidx;

  logic [D_W:0]     rem_sh;
  logic             rem_ge;
  logic [15:0]      trial;
  logic [31:0]      trial_sq;
  logic             sat;
  logic             rnz;
  logic             dz;
  logic             gt_thr, gt4, gt3, gt2;
  logic [1:0]       sev;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign rem_sh   = {rem[D_W-1:0], num[NUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, cur.d});
  assign trial    = root_k | (16'd1 << bidx);
  assign trial_sq = 32'(trial) * 32'(trial);
  assign sat      = |quo[NUM_W-1:32];
  assign rnz      = (rem != '0);
  assign dz       = (cur.d == '0);

  // exact z > t/256 from quotient and remainder of 65536*a^2 / d
  function automatic logic z_gt(input logic [NUM_W-1:0] q, input logic r_nz,
                                input logic [31:0] tq);
    logic [NUM_W-1:0] t_ext;
    t_ext = NUM_W'(tq);
    return (q > t_ext) || ((q == t_ext) && r_nz);
  endfunction

  assign gt_thr = !dz && z_gt(quo, rnz, tsq);
  assign gt4    = !dz && z_gt(quo, rnz, Z4_SQ);
  assign gt3    = !dz && z_gt(quo, rnz, Z3_SQ);
  assign gt2    = !dz && z_gt(quo, rnz, Z2_SQ);

  // severity priority
  always_comb begin
    if (cur.root)                       sev = SEV_CRIT;
    else if (gt4)                       sev = SEV_CRIT;
    else if (cur.logins > LOGINS_CRIT)  sev = SEV_CRIT;
    else if (gt3)                       sev = SEV_HIGH;
    else if (cur.logins > LOGINS_HIGH)  sev = SEV_HIGH;
    else if (cur.scans > SCANS_HIGH)    sev = SEV_HIGH;
    else if (cur.logins > LOGINS_MED)   sev = SEV_MED;
    else if (cur.scans > SCANS_MED)     sev = SEV_MED;
    else if (gt2)                       sev = SEV_MED;
    else                                sev = SEV_LOW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = B_SQ;
        end
      end
      B_SQ:   state_next = dz ? B_DONE : B_DIV;
      B_DIV:  if (step == 6'(NUM_W - 1)) state_next = B_ROOT;
      B_ROOT: if (bidx == 4'd0) state_next = B_DONE;
      B_DONE: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur <= job;
      end
      B_SQ: begin
        num    <= {(2*SUM_W)'(cur.a) * (2*SUM_W)'(cur.a), 16'd0};
        quo    <= '0;
        rem    <= '0;
        step   <= '0;
        tsq    <= 32'(z_threshold) * 32'(z_threshold);
        root_k <= '0;
        bidx   <= 4'd15;
      end
      B_DIV: begin
        num  <= {num[NUM_W-2:0], 1'b0};
        quo  <= {quo[NUM_W-2:0], rem_ge};
        rem  <= rem_ge ? rem_sh - {1'b0, cur.d} : rem_sh;
        step <= step + 6'd1;
      end
      B_ROOT: begin
        if (trial_sq <= quo[31:0]) root_k <= trial;
        bidx <= bidx - 4'd1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      z_score  <= dz ? 16'd0 : (sat ? 16'hFFFF : root_k);
      anomaly  <= gt_thr;
      severity <= sev;
      report   <= (sev != SEV_LOW) || gt_thr;
    end
  end

endmodule

// ----- hw/rtl/swz_checker.sv -----
// Port-level checks for the z-score detector, bound to the top level.
// Depends on swz_pkg and the assertion macro header.
`include "sliding_window_zscore_severity_macros.svh"
module swz_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] z_score,
  input logic        anomaly,
  input logic [1:0]  severity,
  input logic        report
);
  import swz_pkg::*;

  // a stalled result stays offered
  `SWZ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  // report follows severity and anomaly
  `SWZ_ASSERT(a_report, out_valid |-> report == (severity != SEV_LOW || anomaly), "report mismatch")
  // a zero score can still be an anomaly at threshold zero; it is then reported
  `SWZ_ASSERT(a_zero_z, out_valid && (z_score == 16'd0) && anomaly |-> report, "zero z anomaly")
  // no result right after reset
  `SWZ_ASSERT_RST(a_reset, rst |=> !out_valid, "result valid after reset")

endmodule

bind sliding_window_zscore_severity swz_checker u_swz_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .z_score   (z_score),
  .anomaly   (anomaly),
  .severity  (severity),
  .report    (report)
);

// ----- tb/sliding_window_zscore_severity_tb.sv -----
// Testbench for the sliding window z-score severity detector.
// Directed table then random items, each result checked against a window and severity predictor.
// Depends on swz_pkg and sliding_window_zscore_severity.
module sliding_window_zscore_severity_tb;
  import swz_pkg::*;

  localparam int ITEM_COUNT = 550;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASES = 8;
  localparam int unsigned LENS [PHASES] = '{1, 2, 3, 64, 127, 0, 8, 60};
  localparam int unsigned THRS [PHASES] = '{0, 65535, 512, 768, 1, 300, 1024, 768};

  typedef struct packed {
    logic [15:0] z;
    logic        anom;
    logic [1:0]  sev;
    logic        rep;
  } zres_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] logins;
    logic [15:0] scans;
    logic        root;
    logic        known;
    zres_t       res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] traffic_sample;
  logic [15:0] login_fails;
  logic [15:0] scan_count;
  logic        root_flag;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] z_score;
  logic        anomaly;
  logic [1:0]  severity;
  logic        report;

  sliding_window_zscore_severity u_top (.*);

  // predictor state
  logic [15:0] ring_mem [WIN_MAX];
  int unsigned fill_n;
  int unsigned wr_ptr;
  longint unsigned run_sum;
  longint unsigned run_sq;
  int unsigned win_len_reg;
  int unsigned zthr_reg;

  zres_t expected_q[$];
  int    fail_count;
  int    mismatch_count;
  int    cycle_count;
  bit    stall_free;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // exact test z > t/256: a*a*65536 > t*t*d
  function automatic bit z_above(longint unsigned a, longint unsigned d, longint unsigned t);
    logic [127:0] lhs;
    logic [127:0] rhs;
    if (d == 0) return 1'b0;
    lhs = 128'(a) * 128'(a) * 128'd65536;
    rhs = 128'(t) * 128'(t) * 128'(d);
    return lhs > rhs;
  endfunction

  function automatic void clear_window();
    fill_n = 0;
    wr_ptr = 0;
    run_sum = 0;
    run_sq = 0;
  endfunction

  function automatic void write_model_reg(swz_reg_e idx, logic [15:0] val);
    if (idx == REG_WINDOW_LENGTH) begin
      win_len_reg = val & 16'h7F;
      clear_window();
    end else begin
      zthr_reg = val;
    end
  endfunction

  // push one sample and classify it
  function automatic zres_t window_zscore(logic [15:0] x, logic [15:0] logins,
                                          logic [15:0] scans, logic root);
    zres_t r;
    int unsigned len;
    longint unsigned n, a, d, ns, old, k, t;
    logic [127:0] lhs;
    logic [127:0] rhs;
    len = (win_len_reg == 0) ? 1 : (win_len_reg > WIN_MAX ? WIN_MAX : win_len_reg);
    if (wr_ptr >= len) wr_ptr = 0;
    if (fill_n >= len) begin
      old = ring_mem[wr_ptr];
      run_sum -= old;
      run_sq -= old * old;
      fill_n = len;
    end else begin
      fill_n++;
    end
    ring_mem[wr_ptr] = x;
    run_sum += x;
    run_sq += longint'(x) * longint'(x);
    wr_ptr = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
    n = fill_n;
    a = 0;
    d = 0;
    if (n >= 2) begin
      ns = n * x;
      a = (ns >= run_sum) ? ns - run_sum : run_sum - ns;
      d = n * run_sq - run_sum * run_sum;
    end
    k = 0;
    if (d != 0) begin
      for (int b = 15; b >= 0; b--) begin
        t = k | (64'd1 << b);
        lhs = 128'(t) * 128'(t) * 128'(d);
        rhs = 128'(a) * 128'(a) * 128'd65536;
        if (lhs <= rhs) k = t;
      end
    end
    r.z = k[15:0];
    r.anom = z_above(a, d, zthr_reg);
    if (root) r.sev = SEV_CRIT;
    else if (z_above(a, d, 1024)) r.sev = SEV_CRIT;
    else if (logins > LOGINS_CRIT) r.sev = SEV_CRIT;
    else if (z_above(a, d, 768)) r.sev = SEV_HIGH;
    else if (logins > LOGINS_HIGH) r.sev = SEV_HIGH;
    else if (scans > SCANS_HIGH) r.sev = SEV_HIGH;
    else if (logins > LOGINS_MED) r.sev = SEV_MED;
    else if (scans > SCANS_MED) r.sev = SEV_MED;
    else if (z_above(a, d, 512)) r.sev = SEV_MED;
    else r.sev = SEV_LOW;
    r.rep = (r.sev != SEV_LOW) || r.anom;
    return r;
  endfunction

  // receiver side: random stall and result check
  always @(posedge clk) begin
    zres_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (mismatch_count++ < 10) $display("unexpected result z=%0d", z_score);
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          if (z_score !== e.z || anomaly !== e.anom || severity !== e.sev
              || report !== e.rep) begin
            fail_count++;
            if (mismatch_count++ < 10)
              $display({"mismatch: exp z=%0d an=%0b sev=%0d rep=%0b",
                        " got z=%0d an=%0b sev=%0d rep=%0b"},
                       e.z, e.anom, e.sev, e.rep, z_score, anomaly, severity, report);
          end
        end
      end
      out_stall <= stall_free ? 1'b0 : ($urandom_range(99) < 11);
    end
  end

  // one register write; write enable is low again before the task returns, so writes never share a time step
  task automatic cfg_put(swz_reg_e idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    write_model_reg(idx, val);
    @(posedge clk);
  endtask

  // wait for all results, then settle before a register write
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // drive one item and hold until accepted
  task automatic send_item(logic [15:0] x, logic [15:0] lg, logic [15:0] sc, logic rt,
                           bit known, zres_t given);
    zres_t p;
    while (!stall_free && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    traffic_sample <= x;
    login_fails    <= lg;
    scan_count     <= sc;
    root_flag      <= rt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = window_zscore(x, lg, sc, rt);
    if (known && p != given) begin
      fail_count++;
      $display("table row disagrees with predictor for sample %0d", x);
    end
    expected_q.insert(expected_q.size(), p);
  endtask

  // directed rows; known results come straight from the rules
  stim_row_t dir_tab [16] = '{
    '{16'd0,     16'd0,     16'd0,     1'b0, 1'b1, '{16'd0, 1'b0, SEV_LOW,  1'b0}},
    '{16'd0,     16'd0,     16'd0,     1'b1, 1'b1, '{16'd0, 1'b0, SEV_CRIT, 1'b1}},
    '{16'd0,     16'd51,    16'd0,     1'b0, 1'b1, '{16'd0, 1'b0, SEV_CRIT, 1'b1}},
    '{16'd0,     16'd50,    16'd0,     1'b0, 1'b1, '{16'd0, 1'b0, SEV_HIGH, 1'b1}},
    '{16'd0,     16'd21,    16'd0,     1'b0, 1'b1, '{16'd0, 1'b0, SEV_HIGH, 1'b1}},
    '{16'd0,     16'd20,    16'd0,     1'b0, 1'b1, '{16'd0, 1'b0, SEV_MED,  1'b1}},
    '{16'd0,     16'd5,     16'd101,   1'b0, 1'b1, '{16'd0, 1'b0, SEV_HIGH, 1'b1}},
    '{16'd0,     16'd5,     16'd100,   1'b0, 1'b1, '{16'd0, 1'b0, SEV_MED,  1'b1}},
    '{16'd0,     16'd6,     16'd0,     1'b0, 1'b1, '{16'd0, 1'b0, SEV_MED,  1'b1}},
    '{16'd0,     16'd0,     16'd11,    1'b0, 1'b1, '{16'd0, 1'b0, SEV_MED,  1'b1}},
    '{16'd0,     16'd0,     16'd10,    1'b0, 1'b1, '{16'd0, 1'b0, SEV_LOW,  1'b0}},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 1'b0, '{16'd0, 1'b0, SEV_LOW,  1'b0}},
    '{16'd0,     16'd0,     16'd0,     1'b0, 1'b0, '{16'd0, 1'b0, SEV_LOW,  1'b0}},
    '{16'hFFFF,  16'd0,     16'd0,     1'b0, 1'b0, '{16'd0, 1'b0, SEV_LOW,  1'b0}},
    '{16'h5555,  16'hAAAA,  16'h5555,  1'b0, 1'b0, '{16'd0, 1'b0, SEV_LOW,  1'b0}},
    '{16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, 1'b0, '{16'd0, 1'b0, SEV_LOW,  1'b0}}
  };

  // random item, mostly a steady baseline with occasional spikes
  task automatic send_random(int unsigned base);
    logic [15:0] x;
    logic [15:0] lg;
    logic [15:0] sc;
    zres_t none;
    none = '{16'd0, 1'b0, SEV_LOW, 1'b0};
    case ($urandom_range(3))
      0: x = 16'($urandom);
      1: x = 16'(base + $urandom_range(2048) - 1024);
      default: x = 16'(base + $urandom_range(64) - 32);
    endcase
    lg = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60));
    sc = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(120));
    send_item(x, lg, sc, $urandom_range(15) == 0, 1'b0, none);
  endtask

  initial begin
    zres_t none;
    none = '{16'd0, 1'b0, SEV_LOW, 1'b0};
    fail_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    stall_free = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WINDOW_LENGTH;
    cfg_data = '0;
    in_valid = 1'b0;
    traffic_sample = '0;
    login_fails = '0;
    scan_count = '0;
    root_flag = 1'b0;
    out_stall = 1'b0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    clear_window();
    win_len_reg = 60;
    zthr_reg = 768;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under reset settings
    foreach (dir_tab[i])
      send_item(dir_tab[i].x, dir_tab[i].logins, dir_tab[i].scans, dir_tab[i].root,
                dir_tab[i].known, dir_tab[i].res);
    // flat window then a spike
    in_valid <= 1'b0;
    drain();
    cfg_put(REG_WINDOW_LENGTH, 16'd4);
    repeat (4) send_item(16'd1000, 16'd0, 16'd0, 1'b0, 1'b0, none);
    send_item(16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, none);
    in_valid <= 1'b0;

    // random phases over several register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      int unsigned base;
      drain();
      cfg_put(REG_WINDOW_LENGTH, 16'(LENS[ph]));
      cfg_put(REG_Z_THRESHOLD, 16'(THRS[ph]));
      stall_free = (ph == 3);
      base = $urandom_range(60000) + 1024;
      for (int i = 0; i < ITEM_COUNT / PHASES; i++) send_random(base);
      in_valid <= 1'b0;
    end
    stall_free = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/swz_pkg.sv
hw/rtl/swz_front.sv
hw/rtl/swz_fifo.sv
hw/rtl/swz_back.sv
hw/rtl/sliding_window_zscore_severity.sv
hw/rtl/swz_checker.sv
tb/sliding_window_zscore_severity_tb.sv
